// ===== design/nas_pkg.sv =====
package nas_pkg;

  // Widths of the item fields.
  localparam int MAX_STATES = 16;
  localparam int MASK_W     = 16;
  localparam int SYM_FIELD_W = 8;
  localparam int IDX_FIELD_W = 4;

  // Item kinds as they arrive on the input port.
  localparam logic [1:0] KIND_STEP  = 2'd0;
  localparam logic [1:0] KIND_TRANS = 2'd1;
  localparam logic [1:0] KIND_ACC   = 2'd2;

  // Operations after classification by the front end.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_STEP,
    OP_TRANS,
    OP_ACC
  } op_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_t                    op;
    logic [IDX_FIELD_W-1:0] idx;
    logic [SYM_FIELD_W-1:0] sym;
    logic [MASK_W-1:0]      mask;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_FINISH
  } back_state_t;

endpackage

// ===== design/nas_front.sv =====
module nas_front #(
  parameter int NUM_STATES = 16,
  parameter int ALPHABET   = 256,
  parameter int NUM_RULES  = 16
) (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        kind,
  input  logic [3:0]        state_index,
  input  logic [7:0]        symbol,
  input  logic [15:0]       active_set,
  input  logic [15:0]       row_data,
  input  logic              q_full,
  input  logic              clearing,
  output logic              cmd_push,
  output nas_pkg::cmd_t     cmd
);
  import nas_pkg::*;

  localparam int NS = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES;
  localparam int NR = (NUM_RULES < MASK_W) ? NUM_RULES : MASK_W;
  localparam logic [MASK_W-1:0] STATE_MASK = MASK_W'((64'd1 << NS) - 64'd1);
  localparam logic [MASK_W-1:0] RULE_MASK  = MASK_W'((64'd1 << NR) - 64'd1);

  logic idx_ok;
  logic sym_ok;

  // Range checks against the configured table sizes.
  assign idx_ok = (32'(state_index) < NS);
  assign sym_ok = (32'(symbol) < ALPHABET);

  // The queue takes a transfer unless it is full or the table is being cleared.
  assign full     = q_full || clearing;
  assign cmd_push = push && !full;

  // Classify the item and trim its masks to the sizes in use.
  always_comb begin
    cmd.idx  = state_index;
    cmd.sym  = symbol;
    cmd.op   = OP_NOP;
    cmd.mask = '0;
    case (kind)
      KIND_STEP: begin
        cmd.op   = OP_STEP;
        cmd.mask = sym_ok ? (active_set & STATE_MASK) : '0;
        if (!sym_ok) begin
          cmd.sym = '0;
        end
      end
      KIND_TRANS: begin
        if (idx_ok && sym_ok) begin
          cmd.op   = OP_TRANS;
          cmd.mask = row_data & STATE_MASK;
        end
      end
      KIND_ACC: begin
        if (idx_ok) begin
          cmd.op   = OP_ACC;
          cmd.mask = row_data & RULE_MASK;
        end
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== design/nas_queue.sv =====
module nas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  nas_pkg::cmd_t wr_cmd,
  output logic          q_full,
  output logic          q_empty,
  input  logic          rd_en,
  output nas_pkg::cmd_t rd_cmd
);
  import nas_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_cmd  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== design/nas_back.sv =====
module nas_back #(
  parameter int NUM_STATES = 16,
  parameter int ALPHABET   = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  nas_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          clearing,
  input  logic          pop,
  output logic          empty,
  output logic [15:0]   next_set,
  output logic          accepting,
  output logic [15:0]   rules_hit,
  output logic [15:0]   rules_seen,
  output logic [31:0]   match_count,
  output logic [31:0]   symbol_count
);
  import nas_pkg::*;

  localparam int NS        = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES;
  localparam int IDX_W     = $clog2(NS);
  localparam int SYM_W     = $clog2(ALPHABET);
  localparam int AW        = IDX_W + SYM_W;
  localparam int MEM_DEPTH = NS * (2 ** SYM_W);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cmd;
  logic [AW-1:0]     clr_addr;
  logic [IDX_W-1:0]  scan_idx;
  logic              rd_take;
  logic [MASK_W-1:0] mem_q;
  logic [MASK_W-1:0] acc;
  logic [MASK_W-1:0] acc_rows [NS];
  logic [MASK_W-1:0] mem [MEM_DEPTH];
  logic              out_valid;

  logic              out_free;
  logic              fin;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [MASK_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [MASK_W-1:0] hit;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (q_cmd.op == OP_STEP) ? BK_SCAN : BK_FINISH;
        end
      end
      BK_SCAN: begin
        if (scan_idx == IDX_W'(NS - 1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_next = BK_FINISH;
      end
      BK_FINISH: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop    = 1'b0;
    clearing = 1'b0;
    fin      = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = {cmd.idx[IDX_W-1:0], cmd.sym[SYM_W-1:0]};
    mem_wd   = cmd.mask;
    case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
        mem_wa   = clr_addr;
        mem_wd   = '0;
      end
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_FINISH: begin
        fin    = out_free;
        mem_we = out_free && (cmd.op == OP_TRANS);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign mem_ra = {scan_idx, cmd.sym[SYM_W-1:0]};

  // Union of the accept rows of all reached states.
  always_comb begin
    hit = '0;
    for (int i = 0; i < NS; i++) begin
      if (acc[i]) begin
        hit = hit | acc_rows[i];
      end
    end
  end

  // Transition table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Command latch, scan index and next-state accumulation.
  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      cmd      <= q_cmd;
      scan_idx <= '0;
      acc      <= '0;
    end else begin
      if (state == BK_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (rd_take) begin
        acc <= acc | mem_q;
      end
    end
  end

  // Result registers, accept rows and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      clr_addr     <= '0;
      rd_take      <= 1'b0;
      out_valid    <= 1'b0;
      rules_seen   <= '0;
      match_count  <= '0;
      symbol_count <= '0;
      for (int i = 0; i < NS; i++) begin
        acc_rows[i] <= '0;
      end
    end else begin
      state   <= state_next;
      rd_take <= (state == BK_SCAN) && cmd.mask[scan_idx];
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      out_valid <= fin || (out_valid && !pop);
      if (fin) begin
        if (cmd.op == OP_ACC) begin
          acc_rows[cmd.idx[IDX_W-1:0]] <= cmd.mask;
        end
        if (cmd.op == OP_STEP) begin
          rules_seen <= rules_seen | hit;
          if (symbol_count != '1) begin
            symbol_count <= symbol_count + 32'd1;
          end
          if ((hit != '0) && (match_count != '1)) begin
            match_count <= match_count + 32'd1;
          end
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fin) begin
      next_set  <= acc;
      rules_hit <= hit;
      accepting <= (hit != '0);
    end
  end

  // A table read is folded in only right after a scan cycle.
  a_take_after_scan: assert property (@(posedge clk) disable iff (rst)
    rd_take |-> $past(state == BK_SCAN))
    else $error("table read accumulated outside a scan");

  // A finished result waits while the output slot is still occupied.
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FINISH && out_valid && !pop) |=> (state == BK_FINISH))
    else $error("result overwritten before transfer");

  // Matching symbols never outnumber symbols seen.
  a_match_le_steps: assert property (@(posedge clk) disable iff (rst)
    match_count <= symbol_count)
    else $error("match count exceeds symbol count");

  // The symbol count never goes down.
  a_steps_monotone: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (symbol_count >= $past(symbol_count)))
    else $error("symbol count decreased");

endmodule

// ===== design/nfa_active_set_step.sv =====
// Flow: an item waits in the two-entry command queue until the back end takes it in
// BK_IDLE; a step item then passes BK_SCAN and BK_DRAIN, a load or unused item does not,
// and the result is registered from BK_FINISH. The back end works on one item at a time;
// a step is limited by the single table read port, which is read once per state.
// Reset: counters, rules seen and accept rows clear at once; then the transition table
// clears one entry per cycle with full high.
module nfa_active_set_step #(
  parameter int NUM_STATES = 16,
  parameter int ALPHABET   = 256,
  parameter int NUM_RULES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [3:0]  state_index,
  input  logic [7:0]  symbol,
  input  logic [15:0] active_set,
  input  logic [15:0] row_data,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] next_set,
  output logic        accepting,
  output logic [15:0] rules_hit,
  output logic [15:0] rules_seen,
  output logic [31:0] match_count,
  output logic [31:0] symbol_count
);
  import nas_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic clearing;

  // Front end: accepts and classifies items.
  nas_front #(
    .NUM_STATES (NUM_STATES),
    .ALPHABET   (ALPHABET),
    .NUM_RULES  (NUM_RULES)
  ) u_front (
    .push        (push),
    .full        (full),
    .kind        (kind),
    .state_index (state_index),
    .symbol      (symbol),
    .active_set  (active_set),
    .row_data    (row_data),
    .q_full      (q_full),
    .clearing    (clearing),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // Command queue between the two ends.
  nas_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_in),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_en   (q_pop),
    .rd_cmd  (cmd_out)
  );

  // Back end: table access, accumulation and result register.
  nas_back #(
    .NUM_STATES (NUM_STATES),
    .ALPHABET   (ALPHABET)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (cmd_out),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .pop          (pop),
    .empty        (empty),
    .next_set     (next_set),
    .accepting    (accepting),
    .rules_hit    (rules_hit),
    .rules_seen   (rules_seen),
    .match_count  (match_count),
    .symbol_count (symbol_count)
  );

endmodule
